### hw/rtl/spsel_pkg.sv
// Shared widths, register indexes, gesture codes and reset values for the swipe page selector.
package spsel_pkg;

  // Fixed field widths
  localparam int PAGE_W  = 3;
  localparam int PCNT_W  = 4;
  localparam int TRAV_W  = 12;
  localparam int DUR_W   = 16;
  localparam int TIME_W  = 32;
  localparam int CIDX_W  = 2;
  localparam int CDATA_W = 16;

  // Parameter defaults
  localparam int MAX_PAGES_DEF  = 8;
  localparam int COORD_BITS_DEF = 12;

  // Configuration register indexes
  localparam logic [CIDX_W-1:0] REG_MIN_TRAVEL   = 2'd0;
  localparam logic [CIDX_W-1:0] REG_MAX_DURATION = 2'd1;
  localparam logic [CIDX_W-1:0] REG_PAGE_COUNT   = 2'd2;

  // Configuration reset values
  localparam logic [TRAV_W-1:0] MIN_TRAVEL_RST   = 12'd40;
  localparam logic [DUR_W-1:0]  MAX_DURATION_RST = 16'd600;
  localparam logic [PCNT_W-1:0] PAGE_COUNT_RST   = 4'd5;

  // Gesture codes
  typedef logic [1:0] gesture_t;
  localparam gesture_t GEST_NONE = 2'd0;
  localparam gesture_t GEST_NEXT = 2'd1;
  localparam gesture_t GEST_PREV = 2'd2;

  // One result beat
  typedef struct packed {
    logic [PAGE_W-1:0] page;
    logic              page_changed;
    gesture_t          gesture;
  } result_t;

endpackage

### hw/rtl/spsel_eval.sv
// Combinational evaluation of one touch sample against the gesture state.
module spsel_eval #(
  parameter int MAX_PAGES  = spsel_pkg::MAX_PAGES_DEF,
  parameter int COORD_BITS = spsel_pkg::COORD_BITS_DEF,
  parameter int AP_W       = $clog2(MAX_PAGES)
) (
  input  logic                          pressed,
  input  logic [COORD_BITS-1:0]         touch_x,
  input  logic [spsel_pkg::TIME_W-1:0]  now_ms,
  input  logic [spsel_pkg::TRAV_W-1:0]  min_travel,
  input  logic [spsel_pkg::DUR_W-1:0]   max_duration,
  input  logic [spsel_pkg::PCNT_W-1:0]  page_count,
  input  logic                          held,
  input  logic [COORD_BITS-1:0]         start_x,
  input  logic [spsel_pkg::TIME_W-1:0]  start_time,
  input  logic [COORD_BITS-1:0]         latest_x,
  input  logic [AP_W-1:0]               active_page,
  output logic                          held_next,
  output logic [COORD_BITS-1:0]         start_x_next,
  output logic [spsel_pkg::TIME_W-1:0]  start_time_next,
  output logic [COORD_BITS-1:0]         latest_x_next,
  output logic [AP_W-1:0]               active_page_next,
  output spsel_pkg::result_t            res
);
  import spsel_pkg::*;

  localparam int CW = ((COORD_BITS > TRAV_W) ? COORD_BITS : TRAV_W) + 2;
  localparam logic [PCNT_W-1:0] MAX_PCNT = PCNT_W'(MAX_PAGES);

  logic [PCNT_W-1:0]   pages;
  logic signed [CW-1:0] dx;
  logic signed [CW-1:0] thr;
  logic [TIME_W-1:0]   dt;
  logic                quick;
  logic [PCNT_W-1:0]   cur_ext;
  logic [PCNT_W-1:0]   fwd;
  logic [PCNT_W-1:0]   back;
  gesture_t            gest;
  logic                changed;

  // Clamp the page count into 1..MAX_PAGES
  always_comb begin
    if (page_count == '0) begin
      pages = PCNT_W'(1);
    end else if (page_count > MAX_PCNT) begin
      pages = MAX_PCNT;
    end else begin
      pages = page_count;
    end
  end

  // Measure travel and elapsed time
  assign dx      = signed'(CW'(latest_x)) - signed'(CW'(start_x));
  assign thr     = signed'(CW'(min_travel));
  assign dt      = now_ms - start_time;
  assign quick   = dt < TIME_W'(max_duration);
  assign cur_ext = PCNT_W'(active_page);
  assign fwd     = cur_ext + PCNT_W'(1);
  assign back    = cur_ext - PCNT_W'(1);

  // Update tracking state and pick the page
  always_comb begin
    held_next        = held;
    start_x_next     = start_x;
    start_time_next  = start_time;
    latest_x_next    = latest_x;
    active_page_next = active_page;
    gest             = GEST_NONE;
    changed          = 1'b0;
    if (pressed) begin
      if (!held) begin
        start_x_next    = touch_x;
        start_time_next = now_ms;
      end
      latest_x_next = touch_x;
      held_next     = 1'b1;
    end else begin
      if (held && quick) begin
        if (dx < -thr) begin
          gest = GEST_NEXT;
          if (fwd < pages) begin
            active_page_next = AP_W'(fwd);
            changed          = 1'b1;
          end
        end else if (dx > thr) begin
          gest = GEST_PREV;
          if (active_page != '0 && back < pages) begin
            active_page_next = AP_W'(back);
            changed          = 1'b1;
          end
        end
      end
      held_next     = 1'b0;
      latest_x_next = '0;
      start_x_next  = '0;
    end
  end

  assign res.page         = PAGE_W'(active_page_next);
  assign res.page_changed = changed;
  assign res.gesture      = gest;

endmodule

### hw/rtl/swipe_page_selector.sv
// Top level of the swipe page selector: handshakes, registers and gesture state.
//
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+-------------------------------
//  sample   | in        | in_valid / in_ready    | pressed, touch_x, now_ms
//  result   | out       | out_valid / out_ready  | page, page_changed, gesture
//  config   | in        | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One sample beat is accepted per cycle while no stalled result holds the input register;
// its result beat passes the input register, then evaluation into the result register.
// The gesture state is updated as the sample leaves the input register, so
// the next sample always sees it. A stalled result holds the input register;
// the input side still takes a beat whenever that register is empty or moving.
// Reset clears the gesture state, the page and all valid flags, and loads the
// configuration defaults. Configuration writes are taken in any cycle.
module swipe_page_selector #(
  parameter int MAX_PAGES  = spsel_pkg::MAX_PAGES_DEF,
  parameter int COORD_BITS = spsel_pkg::COORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          pressed,
  input  logic [COORD_BITS-1:0]         touch_x,
  input  logic [spsel_pkg::TIME_W-1:0]  now_ms,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [spsel_pkg::PAGE_W-1:0]  page,
  output logic                          page_changed,
  output spsel_pkg::gesture_t           gesture,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [spsel_pkg::CIDX_W-1:0]  cfg_index,
  input  logic [spsel_pkg::CDATA_W-1:0] cfg_data
);
  import spsel_pkg::*;

  localparam int AP_W = $clog2(MAX_PAGES);

  // Configuration registers
  logic [TRAV_W-1:0] min_travel;
  logic [DUR_W-1:0]  max_duration;
  logic [PCNT_W-1:0] page_count;

  // Gesture state
  logic              held;
  logic [COORD_BITS-1:0] start_x;
  logic [TIME_W-1:0] start_time;
  logic [COORD_BITS-1:0] latest_x;
  logic [AP_W-1:0]   active_page;

  logic              held_next;
  logic [COORD_BITS-1:0] start_x_next;
  logic [TIME_W-1:0] start_time_next;
  logic [COORD_BITS-1:0] latest_x_next;
  logic [AP_W-1:0]   active_page_next;

  // Input register
  logic              s1_valid;
  logic              s1_pressed;
  logic [COORD_BITS-1:0] s1_x;
  logic [TIME_W-1:0] s1_now;
  logic              s1_adv;

  // Result register
  result_t           res;
  result_t           out_res;

  assign s1_adv    = s1_valid && (!out_valid || out_ready);
  assign in_ready  = !s1_valid || s1_adv;
  assign cfg_ready = 1'b1;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      min_travel   <= MIN_TRAVEL_RST;
      max_duration <= MAX_DURATION_RST;
      page_count   <= PAGE_COUNT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_MIN_TRAVEL:   min_travel   <= cfg_data[TRAV_W-1:0];
        REG_MAX_DURATION: max_duration <= cfg_data[DUR_W-1:0];
        REG_PAGE_COUNT:   page_count   <= cfg_data[PCNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Capture a sample beat
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_pressed <= pressed;
      s1_x       <= touch_x;
      s1_now     <= now_ms;
    end
  end

  spsel_eval #(
    .MAX_PAGES  (MAX_PAGES),
    .COORD_BITS (COORD_BITS),
    .AP_W       (AP_W)
  ) u_eval (
    .pressed          (s1_pressed),
    .touch_x          (s1_x),
    .now_ms           (s1_now),
    .min_travel       (min_travel),
    .max_duration     (max_duration),
    .page_count       (page_count),
    .held             (held),
    .start_x          (start_x),
    .start_time       (start_time),
    .latest_x         (latest_x),
    .active_page      (active_page),
    .held_next        (held_next),
    .start_x_next     (start_x_next),
    .start_time_next  (start_time_next),
    .latest_x_next    (latest_x_next),
    .active_page_next (active_page_next),
    .res              (res)
  );

  // Advance gesture state as the sample moves into the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      held        <= 1'b0;
      start_x     <= '0;
      start_time  <= '0;
      latest_x    <= '0;
      active_page <= '0;
    end else if (s1_adv) begin
      held        <= held_next;
      start_x     <= start_x_next;
      start_time  <= start_time_next;
      latest_x    <= latest_x_next;
      active_page <= active_page_next;
    end
  end

  // Hold the result beat until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_res <= res;
    end
  end

  assign page         = out_res.page;
  assign page_changed = out_res.page_changed;
  assign gesture      = out_res.gesture;

endmodule

### tb/sv/swipe_page_selector_tb.sv
// Self-checking testbench for the swipe page selector: random touch gestures against a page tracker.
module swipe_page_selector_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import spsel_pkg::*;

  localparam int COORD_W = COORD_BITS_DEF;
  localparam int MAX_PG = MAX_PAGES_DEF;
  localparam int X_MAX = (1 << COORD_W) - 1;
  // Index 3 decodes to no register; writes there must be dropped
  localparam logic [CIDX_W-1:0] REG_SPARE = 2'd3;
  localparam int IDLE_PCT = 37;
  localparam int HOLD_CYCLES = 300;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int PHASES = 12;
  localparam int PHASE_SAMPLES = 152;
  localparam int NOISE_PCT = 15;
  localparam int REPORT_CAP = 100;

  // Track page state and hold the page results still to come
  class page_tracker;
    logic [TRAV_W-1:0] min_travel;
    logic [DUR_W-1:0] max_duration;
    logic [PCNT_W-1:0] page_count;
    bit held;
    logic [COORD_W-1:0] start_x;
    logic [COORD_W-1:0] latest_x;
    logic [TIME_W-1:0] start_time;
    logic [PAGE_W-1:0] active_page;
    result_t pending_pages[$];
    int mismatches;
    int samples;
    int next_swipes;
    int prev_swipes;
    int page_moves;

    function new();
      min_travel = MIN_TRAVEL_RST;
      max_duration = MAX_DURATION_RST;
      page_count = PAGE_COUNT_RST;
      held = 1'b0;
      start_x = '0;
      latest_x = '0;
      start_time = '0;
      active_page = '0;
    endfunction

    function void write_register(logic [CIDX_W-1:0] idx, logic [CDATA_W-1:0] data);
      case (idx)
        REG_MIN_TRAVEL: min_travel = data[TRAV_W-1:0];
        REG_MAX_DURATION: max_duration = data[DUR_W-1:0];
        REG_PAGE_COUNT: page_count = data[PCNT_W-1:0];
        default: ;
      endcase
    endfunction

    // Move only to a different page inside the clamped page range
    function bit move_to(int target);
      int limit;
      limit = (page_count == 0) ? 1 : ((page_count > MAX_PG) ? MAX_PG : int'(page_count));
      if (target < 0 || target >= limit || target == int'(active_page)) return 1'b0;
      active_page = target[PAGE_W-1:0];
      return 1'b1;
    endfunction

    function void note_sample(bit pr, logic [COORD_W-1:0] x, logic [TIME_W-1:0] now);
      result_t r;
      int lx;
      int sx;
      int dx;
      int thr;
      int cur;
      logic [TIME_W-1:0] elapsed;
      r.gesture = GEST_NONE;
      r.page_changed = 1'b0;
      samples++;
      if (pr) begin
        if (!held) begin
          start_x = x;
          start_time = now;
        end
        latest_x = x;
        held = 1'b1;
      end else begin
        if (held) begin
          lx = int'(latest_x);
          sx = int'(start_x);
          thr = int'(min_travel);
          cur = int'(active_page);
          dx = lx - sx;
          elapsed = now - start_time;
          if (elapsed < TIME_W'(max_duration)) begin
            if (dx < -thr) begin
              r.gesture = GEST_NEXT;
              r.page_changed = move_to(cur + 1);
              next_swipes++;
            end else if (dx > thr) begin
              r.gesture = GEST_PREV;
              r.page_changed = move_to(cur - 1);
              prev_swipes++;
            end
          end
        end
        held = 1'b0;
        latest_x = '0;
        start_x = '0;
      end
      if (r.page_changed) page_moves++;
      r.page = active_page;
      pending_pages.push_back(r);
    endfunction

    function void report(string what, int want, int got);
      mismatches++;
      if (mismatches <= REPORT_CAP)
        $display("%0t mismatch %s: expected %0d actual %0d", $time, what, want, got);
    endfunction

    function void check_result(logic [PAGE_W-1:0] pg, logic chg, gesture_t g);
      result_t want;
      if (pending_pages.size() == 0) begin
        report("unexpected result beat, page", -1, int'(pg));
        return;
      end
      want = pending_pages.pop_front();
      if (pg !== want.page) report("page", int'(want.page), int'(pg));
      if (chg !== want.page_changed)
        report("page_changed", int'(want.page_changed), int'(chg));
      if (g !== want.gesture) report("gesture", int'(want.gesture), int'(g));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic pressed = 1'b0;
  logic [COORD_W-1:0] touch_x = '0;
  logic [TIME_W-1:0] now_ms = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [PAGE_W-1:0] page;
  logic page_changed;
  gesture_t gesture;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CIDX_W-1:0] cfg_index = '0;
  logic [CDATA_W-1:0] cfg_data = '0;

  page_tracker tracker;
  bit steady = 1'b0;
  bit hold_request = 1'b0;
  int hold_left = 0;
  int cfg_writes = 0;
  int unsigned quiet_cycles = 0;

  swipe_page_selector dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .pressed(pressed),
    .touch_x(touch_x),
    .now_ms(now_ms),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .page(page),
    .page_changed(page_changed),
    .gesture(gesture),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Offer one sample beat, idling a random number of cycles first
  task automatic send_sample(bit pr, logic [COORD_W-1:0] x, logic [TIME_W-1:0] now);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    pressed <= pr;
    touch_x <= x;
    now_ms <= now;
    do @(posedge clk); while (!in_ready);
    tracker.note_sample(pr, x, now);
  endtask

  // Leaves cfg_valid high; the caller drops it after the last write
  task automatic write_register(logic [CIDX_W-1:0] idx, logic [CDATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    tracker.write_register(idx, data);
    cfg_writes++;
  endtask

  // Load all three registers, plus the spare index when asked; junk in the unused upper data bits must be ignored
  task automatic load_settings(int mt, int md, int pc, bit with_spare);
    write_register(REG_MIN_TRAVEL, {4'($urandom_range(15)), 12'(mt)});
    write_register(REG_MAX_DURATION, 16'(md));
    write_register(REG_PAGE_COUNT, {12'($urandom()), 4'(pc)});
    if (with_spare) write_register(REG_SPARE, 16'($urandom()));
    cfg_valid <= 1'b0;
  endtask

  // Drop valid and wait for every outstanding page result
  task automatic settle();
    in_valid <= 1'b0;
    while (tracker.pending_pages.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Press at x0, move to x1, release at t_rel
  task automatic swipe_once(int x0, int x1, logic [TIME_W-1:0] t0, logic [TIME_W-1:0] t_rel);
    send_sample(1'b1, COORD_W'(x0), t0);
    send_sample(1'b1, COORD_W'(x1), t0 + 1);
    send_sample(1'b0, COORD_W'($urandom_range(X_MAX)), t_rel);
  endtask

  // One touch: press, drag, release, with travel and time often near the limits
  task automatic play_gesture();
    int sx;
    int ex;
    int dx;
    int thr;
    int presses;
    logic [TIME_W-1:0] t0;
    logic [TIME_W-1:0] dur;
    logic [TIME_W-1:0] elapsed;
    thr = int'(tracker.min_travel);
    dur = TIME_W'(tracker.max_duration);
    sx = $urandom_range(X_MAX);
    case ($urandom_range(3))
      0: dx = thr + $urandom_range(2) - 1;
      1: dx = thr + 1 + $urandom_range(400);
      2: dx = $urandom_range(X_MAX);
      default: dx = thr + 1;
    endcase
    if ($urandom_range(1)) dx = -dx;
    ex = sx + dx;
    if (ex < 0 || ex > X_MAX) begin
      ex = sx - dx;
      if (ex < 0 || ex > X_MAX) ex = $urandom_range(X_MAX);
    end
    presses = $urandom_range(1, 5);
    t0 = $urandom();
    send_sample(1'b1, COORD_W'(sx), t0);
    for (int i = 1; i < presses - 1; i++)
      send_sample(1'b1, COORD_W'($urandom_range(X_MAX)), t0 + i);
    if (presses > 1) send_sample(1'b1, COORD_W'(ex), t0 + presses);
    case ($urandom_range(3))
      0: elapsed = (dur == 0) ? '0 : dur - 1;
      1: elapsed = dur;
      2: elapsed = $urandom_range(dur);
      default: elapsed = $urandom();
    endcase
    send_sample(1'b0, COORD_W'($urandom_range(X_MAX)), t0 + elapsed);
  endtask

  // Receive result beats, check them, and pick the next ready
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) tracker.check_result(page, page_changed, gesture);
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // End the run when no beat moves for too long
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t watchdog: no beat for %0d cycles, %0d results outstanding",
                 $time, quiet_cycles, tracker.pending_pages.size());
        $display("FAIL swipe_page_selector");
        $finish;
      end
    end
  end

  initial begin
    int mt;
    int md;
    int pc;
    int target;
    tracker = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed touches at the reset settings
    send_sample(1'b0, COORD_W'(X_MAX), 32'h0);
    swipe_once(X_MAX, 0, 32'hFFFF_FF00, 32'h0000_0100);
    swipe_once(0, X_MAX, 32'd1000, 32'd1599);
    swipe_once(100, 200, 32'd5000, 32'd5020);
    swipe_once(500, 460, 32'd6000, 32'd6020);
    swipe_once(500, 540, 32'd6100, 32'd6120);
    swipe_once(1000, 100, 32'd7000, 32'd7600);
    settle();

    // Random phases, each under its own register settings
    for (int phase = 0; phase < PHASES; phase++) begin
      case ($urandom_range(3))
        0: mt = 0;
        1: mt = X_MAX;
        2: mt = $urandom_range(200);
        default: mt = $urandom_range(X_MAX);
      endcase
      case ($urandom_range(3))
        0: md = 0;
        1: md = 16'hFFFF;
        2: md = $urandom_range(50, 3000);
        default: md = $urandom_range(16'hFFFF);
      endcase
      pc = $urandom_range(15);
      case (phase)
        0: begin
          mt = 0;
          md = 16'hFFFF;
          pc = MAX_PG;
        end
        1: begin
          mt = X_MAX;
          md = 0;
          pc = 0;
        end
        2: begin
          mt = $urandom_range(100);
          md = $urandom_range(500, 3000);
          pc = 15;
        end
        3: begin
          mt = $urandom_range(60);
          md = 16'hFFFF;
          pc = MAX_PG;
        end
        4: begin
          md = 16'hFFFF;
          pc = 2;
        end
        5: pc = 1;
        default: ;
      endcase
      load_settings(mt, md, pc, phase == 0);
      steady = (phase == 6);
      if (phase == 2) hold_request = 1'b1;
      target = tracker.samples + PHASE_SAMPLES;
      while (tracker.samples < target) begin
        if ($urandom_range(99) < NOISE_PCT)
          send_sample(1'($urandom_range(1)), COORD_W'($urandom_range(X_MAX)), $urandom());
        else
          play_gesture();
      end
      settle();
      steady = 1'b0;
    end

    $display("Ran %0d touch samples under %0d register writes: %0d next and %0d previous swipes,",
             tracker.samples, cfg_writes, tracker.next_swipes, tracker.prev_swipes);
    $display("%0d page moves, one %0d-cycle receiver stall; %0d field mismatches.",
             tracker.page_moves, HOLD_CYCLES, tracker.mismatches);
    if (tracker.mismatches == 0)
      $display("PASS swipe_page_selector");
    else
      $display("FAIL swipe_page_selector");
    $finish;
  end

endmodule
